@@ rtl/hmwps_pkg.sv @@
package hmwps_pkg;

	localparam int PixW = 14;
	localparam int OutW = 8;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_CLEAR,
		ST_SCAN,
		ST_PEAK,
		ST_FINISH
	} state_t;

	// one queued item
	typedef struct packed {
		logic            cmd;
		logic [PixW-1:0] pix;
		logic            fend;
	} item_t;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

endpackage

@@ rtl/hmwps_queue.sv @@
module hmwps_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hmwps_pkg::item_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output hmwps_pkg::item_t out_item
);
	import hmwps_pkg::*;

	// two-entry queue between front and back
	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/hmwps_core.sv @@
module hmwps_core #(
	parameter int ROWS = 60,
	parameter int COLS = 80,
	parameter int SMOOTH_DEPTH = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hmwps_pkg::item_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       pixel_out,
	output logic             last_of_frame,
	output logic             not_ready
);
	import hmwps_pkg::*;

	localparam int PIXEL_BITS = PixW;
	localparam int Cap   = ROWS * COLS;
	localparam int CntW  = $clog2(Cap + 1);
	localparam int AddrW = (Cap > 1) ? $clog2(Cap) : 1;
	localparam int Bins  = 1 << PIXEL_BITS;
	localparam int HW    = $clog2(Cap + 1);
	localparam int HPW   = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
	localparam int FillW = $clog2(SMOOTH_DEPTH + 1);
	localparam int SumW  = PIXEL_BITS + $clog2(SMOOTH_DEPTH + 1);
	localparam int OffW  = PIXEL_BITS + 3;
	localparam logic [PIXEL_BITS-1:0] PixMax = {PIXEL_BITS{1'b1}};
	// reciprocal of the history depth, exact floor for any SumW-bit sum
	localparam int DivL  = $clog2(SMOOTH_DEPTH);
	localparam int DivS  = SumW + DivL;
	localparam longint unsigned DivRecip =
		((64'd1 << DivS) + 64'(SMOOTH_DEPTH) - 64'd1) / 64'(SMOOTH_DEPTH);
	localparam logic [SumW:0] DivM = (SumW+1)'(DivRecip);

	// storage
	logic [PIXEL_BITS-1:0] frame_mem [Cap];
	logic [HW-1:0]         hist_mem  [Bins];
	logic [PIXEL_BITS-1:0] hist_q    [SMOOTH_DEPTH];

	state_t state_q, state_d;
	logic [PIXEL_BITS-1:0] min_q, max_q, scan_q, mode_q;
	logic [HW-1:0]   best_q;
	logic [CntW-1:0] load_q, read_q;
	logic            ready_q;
	logic [FillW-1:0] fill_q;
	logic [HPW-1:0]  hptr_q;
	logic [SumW-1:0] sum_q;
	logic signed [OffW-1:0] off_q;
	logic signed [OffW-1:0] peak_q;

	// histogram read-modify-write pipeline
	logic                  upd_s1;
	logic [PIXEL_BITS-1:0] upd_bin_s1;
	logic [HW-1:0]         hrd_s1;
	logic                  scan_s1;
	logic [PIXEL_BITS-1:0] scan_bin_s1;
	logic                  scan_last_s1;

	// output register
	logic       ov_q;
	logic [7:0] po_q;
	logic       pl_q, pn_q;
	logic [PIXEL_BITS-1:0] frd_s1;
	logic signed [OffW-1:0] fval;
	logic       fetch_s1, flast_s1;

	logic [PIXEL_BITS-1:0] pix;
	logic is_load, is_fetch, take, store_ok, fetch_ok;
	logic [PIXEL_BITS-1:0] fmin, fmax;

	assign pix = in_item.pix[PIXEL_BITS-1:0];
	assign store_ok = (load_q < CntW'(Cap));
	assign fetch_ok = ready_q && (read_q < load_q);

	// a load or fetch is taken in run state only with none in flight; output slot must be free
	assign in_ready = (state_q == ST_RUN) && !upd_s1 && !(ov_q && !out_ready)
		&& !fetch_s1;
	assign take     = in_valid && in_ready;
	assign is_load  = take && (in_item.cmd == CMD_LOAD);
	assign is_fetch = take && (in_item.cmd == CMD_FETCH);

	assign fmin = (min_q > max_q) ? '0 : min_q;
	assign fmax = (min_q > max_q) ? '0 : max_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN:    if (is_load && in_item.fend) state_d = ST_SCAN;
			ST_SCAN:   if (scan_s1 && scan_last_s1) state_d = ST_PEAK;
			ST_PEAK:   state_d = ST_FINISH;
			ST_FINISH: state_d = ST_CLEAR;
			ST_CLEAR:  if (scan_q == PixMax) state_d = ST_RUN;
			default:   state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (is_load && store_ok && !(ready_q)) frame_mem[load_q[AddrW-1:0]] <= pix;
		else if (is_load && ready_q) frame_mem[0] <= pix;
		if (fetch_ok) frd_s1 <= frame_mem[read_q[AddrW-1:0]];
		hrd_s1 <= hist_mem[(state_q == ST_SCAN) ? scan_q : pix];
		upd_bin_s1 <= pix;
		scan_bin_s1 <= scan_q;
		if (state_q == ST_CLEAR) hist_mem[scan_q] <= '0;
		else if (upd_s1) hist_mem[upd_bin_s1] <= hrd_s1 + HW'(1);
	end

	// offset-corrected pixel from the registered read
	assign fval = OffW'(frd_s1) - off_q;

	// smoothing arithmetic for the peak and finish states
	logic [PIXEL_BITS-1:0] moff;
	logic [SumW-1:0] nsum;
	logic [2*SumW:0] prod;
	logic [PIXEL_BITS-1:0] quot;
	logic signed [OffW-1:0] size, low;
	assign moff = mode_q - fmin;
	assign nsum = sum_q + SumW'(moff);
	assign prod = (2*SumW+1)'(nsum) * (2*SumW+1)'(DivM);
	assign quot = prod[DivS +: PIXEL_BITS];
	always_comb begin
		size = OffW'(fmax) - OffW'(fmin) + OffW'(1);
		if (peak_q < OffW'(127)) low = '0;
		else if (peak_q + OffW'(128) > size) low = size - OffW'(255);
		else low = peak_q - OffW'(127);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= PixMax; max_q <= '0; scan_q <= '0; mode_q <= '0; best_q <= '0;
			load_q <= '0; read_q <= '0; ready_q <= 1'b0; fill_q <= '0;
			hptr_q <= '0; sum_q <= '0; off_q <= '0; peak_q <= '0; upd_s1 <= 1'b0;
			scan_s1 <= 1'b0; scan_last_s1 <= 1'b0; ov_q <= 1'b0;
			po_q <= '0; pl_q <= 1'b0; pn_q <= 1'b0; fetch_s1 <= 1'b0; flast_s1 <= 1'b0;
		end else begin
			upd_s1   <= 1'b0;
			scan_s1  <= 1'b0;
			fetch_s1 <= 1'b0;
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_CLEAR: scan_q <= scan_q + 1'b1;
				ST_RUN: begin
					if (is_load) begin
						if (ready_q) begin
							ready_q <= 1'b0;
							load_q  <= CntW'(1);
							upd_s1  <= 1'b1;
							min_q <= pix; max_q <= pix;
						end else if (store_ok) begin
							load_q <= load_q + 1'b1;
							upd_s1 <= 1'b1;
							if (pix < min_q) min_q <= pix;
							if (pix > max_q) max_q <= pix;
						end
						if (in_item.fend) begin
							scan_q <= (ready_q || (store_ok && (min_q > max_q || pix < min_q))) ?
								pix : fmin;
							best_q <= '0;
							mode_q <= '0;
						end
					end
					if (is_fetch) begin
						fetch_s1 <= fetch_ok;
						if (fetch_ok) begin
							read_q <= read_q + 1'b1;
							flast_s1 <= (read_q + 1'b1 >= load_q);
							if (read_q + 1'b1 >= load_q) begin
								ready_q <= 1'b0; load_q <= '0;
							end
						end else begin
							ov_q <= 1'b1; po_q <= '0; pl_q <= 1'b0; pn_q <= 1'b1;
						end
					end
					if (fetch_s1) begin
						ov_q <= 1'b1; pn_q <= 1'b0; pl_q <= flast_s1;
						po_q <= (fval < 0) ? 8'd0 :
							(fval > OffW'(255)) ? 8'd255 : fval[7:0];
					end
				end
				ST_SCAN: begin
					if (!upd_s1) begin
						scan_s1 <= (scan_q <= fmax) && !scan_s1 ? 1'b1 : 1'b0;
						scan_last_s1 <= (scan_q >= fmax);
						if (!scan_s1 && scan_q == fmin) mode_q <= fmin;
					end
					if (scan_s1) begin
						if (hrd_s1 > best_q) begin
							best_q <= hrd_s1; mode_q <= scan_bin_s1;
						end
						if (!scan_last_s1) scan_q <= scan_q + 1'b1;
					end
				end
				// smoothed peak: average once the history is full, else raw offset
				ST_PEAK: begin
					peak_q <= (fill_q + 1'b1 >= FillW'(SMOOTH_DEPTH)) ? OffW'(quot) :
						OffW'(moff);
				end
				ST_FINISH: begin
					hist_q[hptr_q] <= moff;
					hptr_q <= (hptr_q == HPW'(SMOOTH_DEPTH - 1)) ? '0 : hptr_q + 1'b1;
					if (fill_q + 1'b1 >= FillW'(SMOOTH_DEPTH))
						sum_q <= nsum - SumW'((SMOOTH_DEPTH == 1) ? moff :
							hist_q[(hptr_q == HPW'(SMOOTH_DEPTH - 1)) ? '0 : hptr_q + 1'b1]);
					else begin
						sum_q <= nsum; fill_q <= fill_q + 1'b1;
					end
					off_q <= low + OffW'(fmin);
					min_q <= PixMax; max_q <= '0;
					ready_q <= 1'b1; read_q <= '0;
					scan_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid     = ov_q;
	assign pixel_out     = po_q;
	assign last_of_frame = pl_q;
	assign not_ready     = pn_q;

endmodule

@@ rtl/histogram_mode_window_pixel_scale.sv @@
// channel | signals                            | role
// in      | in_valid in_ready cmd pixel_in frame_end | load or fetch item
// out     | out_valid out_ready pixel_out last_of_frame not_ready | result item
// a load updates the histogram by read-modify-write; a fetch reads frame memory
// into a register; frame end scans the histogram from min to max, bin by bin,
// then the peak and finish states place the window, then all histogram bins
// are cleared, one per cycle; the same clear runs after reset
// a two-entry queue decouples the port from the core; an output stall holds the result and blocks new items
module histogram_mode_window_pixel_scale #(
	parameter int ROWS = 60,
	parameter int COLS = 80,
	parameter int SMOOTH_DEPTH = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [13:0] pixel_in,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] pixel_out,
	output logic       last_of_frame,
	output logic       not_ready
);
	import hmwps_pkg::*;

	item_t in_item, q_item;
	logic  q_valid, q_ready;

	assign in_item = '{cmd: cmd, pix: pixel_in, fend: frame_end};

	// front queue
	hmwps_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	// back end
	hmwps_core #(.ROWS(ROWS), .COLS(COLS),
		.SMOOTH_DEPTH(SMOOTH_DEPTH)) u_core (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_ready(q_ready),
		.in_item(q_item), .out_valid(out_valid), .out_ready(out_ready),
		.pixel_out(pixel_out), .last_of_frame(last_of_frame), .not_ready(not_ready)
	);

endmodule

@@ rtl/hmwps_checker.sv @@
module hmwps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_out,
	input logic       last_of_frame,
	input logic       not_ready
);
	// a not-ready result carries no pixel
	a_nr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_ready |-> pixel_out == 8'd0 && !last_of_frame)
		else $error("not_ready item with data");
	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out))
		else $error("output changed while stalled");
	// no result out of reset
	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result during reset");
	// input handshake is known outside reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready}))
		else $error("input handshake unknown");
endmodule

bind histogram_mode_window_pixel_scale hmwps_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .pixel_out(pixel_out),
	.last_of_frame(last_of_frame), .not_ready(not_ready)
);

@@ tb/tb_histogram_mode_window_pixel_scale.sv @@
module tb_histogram_mode_window_pixel_scale;
	timeunit 1ns;
	timeprecision 1ps;
	import hmwps_pkg::*;

	localparam int FRAME_CAP = 60 * 80;
	localparam int AVG_DEPTH = 20;
	localparam int IDLE_LIMIT = 200000;

	// expected result of one fetch
	typedef struct {
		logic [7:0] pix;
		logic       last;
		logic       nrdy;
	} scaled_t;

	// tracks block state and compares fetched pixels
	class agc_scoreboard;
		logic [13:0] frame_pix [FRAME_CAP];
		int unsigned hist [int unsigned];
		int unsigned fmin, fmax;
		int unsigned offs_hist [AVG_DEPTH];
		int unsigned fill, wptr, sum, n_loaded, n_read;
		bit ready;
		int offset;
		scaled_t pending [$];
		int errors;

		function void clear_stats();
			hist.delete();
			fmin = 16383;
			fmax = 0;
		endfunction

		function void init();
			clear_stats();
			fill = 0; wptr = 0; sum = 0; n_loaded = 0; n_read = 0;
			ready = 0; offset = 0; errors = 0;
		endfunction

		// mode search, history smoothing and window placement
		function void close_frame();
			int unsigned best, mode, oldest, v;
			int span, peak, low;
			best = 0;
			mode = fmin;
			if (fmin > fmax) begin
				fmin = 0; fmax = 0; mode = 0;
			end
			for (v = fmin; v <= fmax; v++) begin
				if (hist.exists(v) && hist[v] > best) begin
					best = hist[v];
					mode = v;
				end
			end
			span = int'(fmax - fmin) + 1;
			offs_hist[wptr] = mode - fmin;
			sum += mode - fmin;
			fill++;
			wptr = (wptr + 1) % AVG_DEPTH;
			peak = mode - fmin;
			if (fill >= AVG_DEPTH) begin
				peak = sum / AVG_DEPTH;
				oldest = (wptr + AVG_DEPTH - fill) % AVG_DEPTH;
				sum -= offs_hist[oldest];
				fill--;
			end
			if (peak < 127) low = 0;
			else if (peak + 128 > span) low = span - 255;
			else low = peak - 127;
			offset = low + int'(fmin);
			clear_stats();
			ready = 1;
			n_read = 0;
		endfunction

		function void note_item(logic c, logic [13:0] p, logic fe);
			scaled_t r;
			int val;
			if (c == CMD_LOAD) begin
				if (ready) begin
					ready = 0;
					n_loaded = 0;
				end
				if (n_loaded < FRAME_CAP) begin
					frame_pix[n_loaded] = p;
					n_loaded++;
					if (hist.exists(p)) hist[p]++;
					else hist[p] = 1;
					if (p < fmin) fmin = p;
					if (p > fmax) fmax = p;
				end
				if (fe) close_frame();
				return;
			end
			if (!ready || n_read >= n_loaded) begin
				r = '{8'd0, 1'b0, 1'b1};
			end else begin
				val = int'(frame_pix[n_read]) - offset;
				if (val > 255) val = 255;
				else if (val < 0) val = 0;
				n_read++;
				r.pix = val[7:0];
				r.nrdy = 0;
				r.last = (n_read >= n_loaded);
				if (r.last) begin
					ready = 0;
					n_loaded = 0;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [7:0] p, logic l, logic n);
			scaled_t e;
			if (pending.size() == 0) begin
				$error("unexpected result pixel_out=%0d", p);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (p !== e.pix) begin
				$error("pixel_out exp %0d got %0d", e.pix, p); errors++;
			end
			if (l !== e.last) begin
				$error("last_of_frame exp %0d got %0d", e.last, l); errors++;
			end
			if (n !== e.nrdy) begin
				$error("not_ready exp %0d got %0d", e.nrdy, n); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, cmd, frame_end;
	logic [13:0] pixel_in;
	logic out_valid, out_ready, last_of_frame, not_ready;
	logic [7:0] pixel_out;

	agc_scoreboard sb;
	int idle_cycles;
	int burst_left;

	histogram_mode_window_pixel_scale i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .pixel_in(pixel_in), .frame_end(frame_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_out(pixel_out), .last_of_frame(last_of_frame), .not_ready(not_ready)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// watchdog on accept activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAIL histogram_mode_window_pixel_scale");
			$finish;
		end
	end

	// check results on accept
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(pixel_out, last_of_frame, not_ready);
	end

	// receiver stall pattern: out_ready drawn at random each clock, mostly high
	always @(negedge clk) begin
		int phase;
		phase = ($urandom_range(0, 63) < 24) ? 0 : 1;
		if (!arst_n) out_ready <= 1'b0;
		else if (phase == 0) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// send one item, with burst/gap idling
	task automatic send_item(logic c, logic [13:0] p, logic fe);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= c;
		pixel_in <= p;
		frame_end <= fe;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(c, p, fe);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// well-formed frame: n loads then fetches (some extra)
	task automatic send_frame(int n, int lo, int hi, int extra);
		for (int i = 0; i < n; i++)
			send_item(CMD_LOAD, 14'($urandom_range(lo, hi)), i == n - 1);
		for (int i = 0; i < n + extra; i++)
			send_item(CMD_FETCH, 14'($urandom), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int kind;
		sb = new();
		sb.init();
		idle_cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0; cmd = 1'b0; pixel_in = '0; frame_end = 1'b0;
		out_ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fetch before any frame, extremes, abandoned frame
		send_item(CMD_FETCH, 14'h3fff, 1'b1);
		send_item(CMD_LOAD, 14'h0000, 1'b0);
		send_item(CMD_LOAD, 14'h3fff, 1'b0);
		send_item(CMD_LOAD, 14'h3fff, 1'b1);
		send_item(CMD_FETCH, 14'h0, 1'b0);
		send_item(CMD_LOAD, 14'h1555, 1'b0);
		send_item(CMD_LOAD, 14'h2aaa, 1'b1);
		send_item(CMD_FETCH, 14'h0, 1'b0);
		send_item(CMD_FETCH, 14'h0, 1'b0);
		send_item(CMD_FETCH, 14'h0, 1'b0);
		// single-pixel frame and narrow frame
		send_item(CMD_LOAD, 14'd5000, 1'b1);
		send_item(CMD_FETCH, 14'h0, 1'b0);
		send_frame(4, 100, 140, 1);
		drain();
		// idle pause once all results came in
		repeat (100) @(negedge clk);

		// random: mostly frames, some noise
		for (int k = 0; k < 30; k++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				send_frame($urandom_range(1, 8), 0, 16383, $urandom_range(0, 1));
			end else if (kind < 8) begin
				// narrow spread so the window logic shows nonzero offsets
				send_frame($urandom_range(2, 8), 1000, 1000 + $urandom_range(0, 600), 0);
			end else begin
				for (int i = 0; i < 6; i++)
					send_item(1'($urandom_range(0, 1)), 14'($urandom),
						$urandom_range(0, 3) == 0);
			end
		end
		drain();
		// one long frame with extra fetches past its end
		for (int i = 0; i < 100; i++)
			send_item(CMD_LOAD, 14'($urandom_range(2000, 2400)), i == 99);
		for (int i = 0; i < 102; i++)
			send_item(CMD_FETCH, 14'h0, 1'b0);
		for (int k = 0; k < 10; k++)
			send_frame($urandom_range(1, 6), 0, $urandom_range(0, 16383), 0);

		drain();
		repeat (50) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS histogram_mode_window_pixel_scale");
		else
			$display("FAIL histogram_mode_window_pixel_scale");
		$finish;
	end
endmodule

@@ histogram_mode_window_pixel_scale.f @@
rtl/hmwps_pkg.sv
rtl/hmwps_queue.sv
rtl/hmwps_core.sv
rtl/histogram_mode_window_pixel_scale.sv
rtl/hmwps_checker.sv
tb/tb_histogram_mode_window_pixel_scale.sv
